// ===== design/agm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_pkg
// Shared sizes, codes and types of the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package agm_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ID_WIDTH     = 32;

  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  // field widths on the channels
  localparam int KIND_W       = 3;
  localparam int IN_ID_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int EDGE_TOTAL_W = 13;
  localparam int NID_W        = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_ADD_VERTEX = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEST       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEGREE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COUNTS     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    OP_REPLY,
    OP_NEW_VERTEX,
    OP_ADD_EDGE,
    OP_TEST,
    OP_DEGREE,
    OP_LIST,
    OP_COUNTS
  } op_t;

  // one classified operation, front to back
  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    idx_a;
    logic [IDX_W-1:0]    idx_b;
    logic [CNT_W-1:0]    vcount;
    logic [ID_WIDTH-1:0] id;
  } qent_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    connected;
    logic [COUNT_W-1:0]      count;
    logic [EDGE_TOTAL_W-1:0] edge_total;
    logic [NID_W-1:0]        neighbour_id;
    logic                    neighbour_valid;
    logic                    last;
  } rsp_t;

endpackage
`default_nettype wire

// ===== design/agm_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_req_if
// Request channel: one graph operation per word.
// ----------------------------------------------------------------------------
interface agm_req_if;
  import agm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IN_ID_W-1:0]  id_a;
  logic [IN_ID_W-1:0]  id_b;

  modport source (output valid, output kind, output id_a, output id_b, input ready);
  modport sink   (input valid, input kind, input id_a, input id_b, output ready);
endinterface
`default_nettype wire

// ===== design/agm_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_rsp_if
// Response channel: one result word, several per listing.
// ----------------------------------------------------------------------------
interface agm_rsp_if;
  import agm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    connected;
  logic [COUNT_W-1:0]      count;
  logic [EDGE_TOTAL_W-1:0] edge_total;
  logic [NID_W-1:0]        neighbour_id;
  logic                    neighbour_valid;
  logic                    last;

  modport source (output valid, output status, output connected, output count,
                  output edge_total, output neighbour_id, output neighbour_valid,
                  output last, input ready);
  modport sink   (input valid, input status, input connected, input count,
                  input edge_total, input neighbour_id, input neighbour_valid,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== design/agm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_front
// Accepts requests, matches ids against the vertex table in parallel and
// inserts new vertices; pushes one classified operation into the queue per request of a known kind.
// ----------------------------------------------------------------------------
module agm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  agm_req_if.sink            req,
  output agm_pkg::qent_t     q_data,
  output logic               q_wr,
  input  wire logic          q_full
);
  import agm_pkg::*;

  logic [ID_WIDTH-1:0]     ids [MAX_VERTICES];
  logic [CNT_W-1:0]        vcount;
  logic [ID_WIDTH-1:0]     key_a;
  logic [ID_WIDTH-1:0]     key_b;
  logic [MAX_VERTICES-1:0] hit_a;
  logic [MAX_VERTICES-1:0] hit_b;
  logic [IDX_W-1:0]        idx_a;
  logic [IDX_W-1:0]        idx_b;
  logic                    found_a;
  logic                    found_b;
  logic                    accept;
  logic                    ins;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign key_a     = ID_WIDTH'(req.id_a);
  assign key_b     = ID_WIDTH'(req.id_b);

  // ids are unique, so the hit vectors are one-hot or empty
  always_comb begin
    idx_a = '0;
    idx_b = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      hit_a[i] = (i < int'(vcount)) && (ids[i] == key_a);
      hit_b[i] = (i < int'(vcount)) && (ids[i] == key_b);
      if (hit_a[i]) idx_a = idx_a | IDX_W'(i);
      if (hit_b[i]) idx_b = idx_b | IDX_W'(i);
    end
    found_a = |hit_a;
    found_b = |hit_b;
  end

  always_comb begin
    q_data        = '0;
    q_data.op     = OP_REPLY;
    q_data.status = ST_OK;
    q_data.idx_a  = idx_a;
    q_data.idx_b  = idx_b;
    q_data.vcount = vcount;
    q_data.id     = key_a;
    q_wr          = accept;
    ins           = 1'b0;
    case (req.kind)
      KIND_ADD_VERTEX: begin
        if (found_a) begin
          q_data.status = ST_DUPLICATE;
        end else if (vcount == CNT_W'(MAX_VERTICES)) begin
          q_data.status = ST_FULL;
        end else begin
          q_data.op    = OP_NEW_VERTEX;
          q_data.idx_a = vcount[IDX_W-1:0];
          ins          = accept;
        end
      end
      KIND_ADD_EDGE, KIND_TEST: begin
        if (!found_a || !found_b) begin
          q_data.status = ST_NOT_FOUND;
        end else begin
          q_data.op = (req.kind == KIND_TEST) ? OP_TEST : OP_ADD_EDGE;
        end
      end
      KIND_DEGREE, KIND_LIST: begin
        if (!found_a) begin
          q_data.status = ST_NOT_FOUND;
        end else begin
          q_data.op = (req.kind == KIND_LIST) ? OP_LIST : OP_DEGREE;
        end
      end
      KIND_COUNTS: q_data.op = OP_COUNTS;
      default:     q_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else if (ins) begin
      vcount <= vcount + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ins) ids[vcount[IDX_W-1:0]] <= key_a;
  end

endmodule
`default_nettype wire

// ===== design/agm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_queue
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module agm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire agm_pkg::qent_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output agm_pkg::qent_t      rd_data,
  output logic                empty
);
  import agm_pkg::*;

  qent_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd_en) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (wr_en && !rd_en) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a word");

endmodule
`default_nettype wire

// ===== design/agm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// agm_back
// Carries out queued operations on the adjacency rows, out-degrees and the
// id copy used for listing; drives the registered response.
// ----------------------------------------------------------------------------
module agm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire agm_pkg::qent_t q_data,
  input  wire logic           q_empty,
  output logic                q_rd,
  agm_rsp_if.source           rsp
);
  import agm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LIST} state_t;

  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [CNT_W-1:0]        deg_mem [MAX_VERTICES];
  logic [ID_WIDTH-1:0]     id_mem  [MAX_VERTICES];

  state_t                  state;
  state_t                  state_next;
  qent_t                   ent;
  logic [MAX_VERTICES-1:0] row_q;
  logic [CNT_W-1:0]        deg_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic [EDGE_W-1:0]       edge_count;
  logic [MAX_VERTICES-1:0] pend;
  logic [MAX_VERTICES-1:0] pend_next;
  logic                    rd_pend;
  logic                    rd_pend_next;
  logic                    rd_last;
  logic                    out_valid;
  rsp_t                    out_reg;
  rsp_t                    out_next;
  logic                    out_free;
  logic                    load;
  logic                    fetch;
  logic                    fetch_last;
  logic [MAX_VERTICES-1:0] low_bit;
  logic [IDX_W-1:0]        low_idx;
  logic                    row_we;
  logic [MAX_VERTICES-1:0] row_wdata;
  logic                    deg_we;
  logic [CNT_W-1:0]        deg_wdata;
  logic                    id_we;
  logic                    edge_inc;

  assign out_free = !out_valid || rsp.ready;
  assign q_rd     = (state == S_IDLE) && !q_empty;

  // lowest pending neighbour
  assign low_bit = pend & (~pend + MAX_VERTICES'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (low_bit[i]) low_idx = low_idx | IDX_W'(i);
    end
  end

  always_comb begin
    state_next   = state;
    out_next     = '0;
    out_next.last = 1'b1;
    load         = 1'b0;
    fetch        = 1'b0;
    fetch_last   = ((pend & ~low_bit) == '0);
    pend_next    = pend;
    rd_pend_next = rd_pend;
    row_we       = 1'b0;
    row_wdata    = row_q | (MAX_VERTICES'(1) << ent.idx_b);
    deg_we       = 1'b0;
    deg_wdata    = deg_q + CNT_W'(1);
    id_we        = 1'b0;
    edge_inc     = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_rd) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ent.op == OP_LIST && row_q != '0) begin
          pend_next    = row_q;
          rd_pend_next = 1'b0;
          state_next   = S_LIST;
        end else if (out_free) begin
          load            = 1'b1;
          out_next.status = ent.status;
          state_next      = S_IDLE;
          case (ent.op)
            OP_NEW_VERTEX: begin
              row_we    = 1'b1;
              row_wdata = '0;
              deg_we    = 1'b1;
              deg_wdata = '0;
              id_we     = 1'b1;
            end
            OP_ADD_EDGE: begin
              if (!row_q[ent.idx_b]) begin
                row_we   = 1'b1;
                deg_we   = 1'b1;
                edge_inc = 1'b1;
              end
            end
            OP_TEST:   out_next.connected = row_q[ent.idx_b];
            OP_DEGREE: out_next.count = COUNT_W'(deg_q);
            OP_COUNTS: begin
              out_next.count      = COUNT_W'(ent.vcount);
              out_next.edge_total = EDGE_TOTAL_W'(edge_count);
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        load  = rd_pend && out_free;
        fetch = (pend != '0) && (!rd_pend || load);
        out_next.neighbour_id    = NID_W'(id_q);
        out_next.neighbour_valid = 1'b1;
        out_next.last            = rd_last;
        if (fetch) begin
          pend_next    = pend & ~low_bit;
          rd_pend_next = 1'b1;
        end else if (load) begin
          rd_pend_next = 1'b0;
        end
        if (pend_next == '0 && !rd_pend_next) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      edge_count <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (edge_inc) edge_count <= edge_count + EDGE_W'(1);
    end
    pend <= pend_next;
    if (q_rd) ent <= q_data;
    if (load) out_reg <= out_next;
    if (fetch) rd_last <= fetch_last;
  end

  // memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    if (q_rd) begin
      row_q <= row_mem[q_data.idx_a];
      deg_q <= deg_mem[q_data.idx_a];
    end
    if (row_we) row_mem[ent.idx_a] <= row_wdata;
    if (deg_we) deg_mem[ent.idx_a] <= deg_wdata;
  end

  always_ff @(posedge clk) begin
    if (fetch) id_q <= id_mem[low_idx];
    if (id_we) id_mem[ent.idx_a] <= ent.id;
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_reg.status;
  assign rsp.connected       = out_reg.connected;
  assign rsp.count           = out_reg.count;
  assign rsp.edge_total      = out_reg.edge_total;
  assign rsp.neighbour_id    = out_reg.neighbour_id;
  assign rsp.neighbour_valid = out_reg.neighbour_valid;
  assign rsp.last            = out_reg.last;

endmodule
`default_nettype wire

// ===== design/adjacency_matrix_graph_store_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_core
// Directed graph store: vertex id table with parallel match, adjacency bit
// matrix, out-degrees and counts.
//
//   channel  dir  word                                  handshake
//   req      in   kind, id_a, id_b                      valid / ready
//   rsp      out  status, connected, count, edge_total,  valid / ready
//                 neighbour_id, neighbour_valid, last
//
// The front takes one request a cycle while the 4-word queue has room.
// The back pops an operation with a row and degree memory read and then
// executes it once the response register is free; a listing starts with
// an id memory read, then gives one neighbour per cycle unless rsp stalls.
// Reset empties the vertex table and the queue; no clearing pass is run.
// A stalled rsp holds the back, and the queue then fills and drops req.ready.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_core (
  input  wire logic clk,
  input  wire logic rst,
  agm_req_if.sink   req,
  agm_rsp_if.source rsp
);
  import agm_pkg::*;

  qent_t wr_data;
  qent_t rd_data;
  logic  wr_en;
  logic  rd_en;
  logic  full;
  logic  empty;

  agm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_data (wr_data),
    .q_wr   (wr_en),
    .q_full (full)
  );

  agm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .full    (full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .empty   (empty)
  );

  agm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (rd_data),
    .q_empty (empty),
    .q_rd    (rd_en),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire
